@@ design/phased_periodic_task_scheduler_macros.svh @@
// assertion helpers, clocked on i_clk and held off while i_rst_n is low
`ifndef PHASED_PERIODIC_TASK_SCHEDULER_MACROS_SVH
`define PHASED_PERIODIC_TASK_SCHEDULER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// antecedent implies consequent in the next cycle
`define PTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

@@ design/pts_pkg.sv @@
package pts_pkg;

    localparam int SLOTS     = 4;
    localparam int MAX_SLOTS = 4;
    localparam int SLOT_W    = 2;
    localparam int CNT_W     = 16;
    localparam int ENTRY_W   = 2 * CNT_W;
    localparam int TABLE_W   = 64;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 64;

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_PHASE  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_RUN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [MAX_SLOTS-1:0] mask;
        logic [TABLE_W-1:0]   period;
        logic [TABLE_W-1:0]   phase;
        logic                 phase_wr;
    } t_cfg;

endpackage

@@ design/pts_if.sv @@
interface pts_in_if
    import pts_pkg::*;
();
    logic valid;
    logic ready;
    logic new_tick;

    modport source (output valid, output new_tick, input ready);
    modport sink (input valid, input new_tick, output ready);
endinterface

interface pts_out_if
    import pts_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] fired_slot;
    logic              last_fire;

    modport source (output valid, output fired_slot, output last_fire, input ready);
    modport sink (input valid, input fired_slot, input last_fire, output ready);
endinterface

@@ design/pts_ram.sv @@
module pts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/pts_regs.sv @@
module pts_regs
    import pts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [MAX_SLOTS-1:0] r_mask;
    logic [TABLE_W-1:0]   r_period;
    logic [TABLE_W-1:0]   r_phase;
    logic                 wr;
    logic [1:0]           idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[PADDR_W-1:PADDR_W-2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_period <= '0;
            r_phase  <= '0;
        end else if (wr) begin
            case (idx)
                REG_ENABLE: r_mask   <= pwdata[MAX_SLOTS-1:0];
                REG_PERIOD: r_period <= pwdata[TABLE_W-1:0];
                REG_PHASE:  r_phase  <= pwdata[TABLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ENABLE: prdata = PDATA_W'(r_mask);
            REG_PERIOD: prdata = PDATA_W'(r_period);
            REG_PHASE:  prdata = PDATA_W'(r_phase);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg.mask     = r_mask;
    assign o_cfg.period   = r_period;
    assign o_cfg.phase    = r_phase;
    assign o_cfg.phase_wr = wr && (idx == REG_PHASE);

endmodule

@@ design/pts_engine.sv @@
module pts_engine
    import pts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    pts_in_if.sink  i_req,
    pts_out_if.source o_fire
);

    `include "phased_periodic_task_scheduler_macros.svh"

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_pend_valid, n_pend_valid;
    logic [SLOT_W-1:0] r_pend_slot, n_pend_slot;
    logic              r_out_valid, n_out_valid;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic              r_out_last, n_out_last;

    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [SLOT_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic               slot_en;
    logic [CNT_W-1:0]   cd;
    logic [CNT_W-1:0]   cnt;
    logic [CNT_W-1:0]   per;
    logic [CNT_W:0]     cnt_inc;
    logic               fire;
    logic               out_free;
    logic               stall;

    pts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign slot_en  = i_cfg.mask[r_slot];
    assign cd       = ram_rdata[ENTRY_W-1:CNT_W];
    assign cnt      = ram_rdata[CNT_W-1:0];
    assign per      = i_cfg.period[{r_slot, 4'd0} +: CNT_W];
    assign cnt_inc  = {1'b0, cnt} + (CNT_W+1)'(1);
    assign fire     = (r_state == S_RUN) && slot_en && (cd == '0) && (cnt_inc >= {1'b0, per});
    assign out_free = !r_out_valid || o_fire.ready;
    assign stall    = fire && r_pend_valid && !out_free;

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_fire.valid      = r_out_valid;
    assign o_fire.fired_slot = r_out_slot;
    assign o_fire.last_fire  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_slot       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slot       <= n_slot;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_pend_slot <= n_pend_slot;
        r_out_slot  <= n_out_slot;
        r_out_last  <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_slot       = r_slot;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_out_valid  = r_out_valid && !o_fire.ready;
        n_out_slot   = r_out_slot;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = r_slot;
        ram_wdata    = '0;
        ram_raddr    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid && i_req.new_tick) begin
                    n_state = S_RUN;
                    n_slot  = '0;
                end
            end
            S_SWEEP: begin
                ram_we    = 1'b1;
                ram_wdata = {i_cfg.phase[{r_slot, 4'd0} +: CNT_W], CNT_W'(0)};
                n_slot    = r_slot + SLOT_W'(1);
                if (r_slot == SLOT_W'(MAX_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_RUN: begin
                if (stall) begin
                    ram_raddr = r_slot;
                end else begin
                    ram_raddr = r_slot + SLOT_W'(1);
                    ram_we    = slot_en;
                    if (cd != '0) begin
                        ram_wdata = {cd - CNT_W'(1), cnt};
                    end else if (fire) begin
                        ram_wdata = {cd, CNT_W'(0)};
                    end else begin
                        ram_wdata = {cd, cnt_inc[CNT_W-1:0]};
                    end
                    if (fire) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_slot  = r_pend_slot;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_slot  = r_slot;
                    end
                    if (r_slot == SLOT_W'(SLOTS - 1)) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_slot = r_slot + SLOT_W'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_slot   = r_pend_slot;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // phase reload restarts the clearing pass
        if (i_cfg.phase_wr) begin
            n_state = S_SWEEP;
            n_slot  = '0;
        end
    end

    `PTS_ASSERT_NOW(a_stall_only_run, stall, r_state == S_RUN)
    `PTS_ASSERT_NOW(a_write_enabled, (r_state == S_RUN) && ram_we, slot_en && !stall)
    `PTS_ASSERT_NEXT(a_fire_pends, fire && !stall && !i_cfg.phase_wr,
        r_pend_valid && (r_pend_slot == $past(r_slot)))
    `PTS_ASSERT_NEXT(a_flush_drains, (r_state == S_FLUSH) && (n_state == S_IDLE),
        !r_pend_valid)
    `PTS_ASSERT_NEXT(a_phase_sweep, i_cfg.phase_wr, (r_state == S_SWEEP) && (r_slot == '0))

endmodule

@@ design/phased_periodic_task_scheduler.sv @@
// phased periodic task scheduler
// i_req carries one scheduler pass per request; new_tick says a tick has come
// since the previous pass. o_fire carries one request per slot whose period ran
// out on that tick, in slot order, with last_fire set on the final one.
// configuration goes over the apb port: enable mask at 0x00, period table at
// 0x08, phase table at 0x10, 64-bit data, pready tied high.
// a pass without a tick gives nothing. in a pass with a tick the per-slot
// countdown and counter sit in one single-port-write state memory, visited
// one slot per cycle while no stall holds the scan, with the read of the next
// slot issued ahead; then a flush state drains the held last result.
// each fire request waits in a pending register before the output register.
// results go through an output register, so the next pass can start while the
// last result still waits; a stalled receiver holds the scan only when a second
// fire needs the output register.
// after reset, and after every phase table write, a clearing pass loads the
// state memory (countdowns from the phase table, counters zero) while
// i_req.ready is low; configuration writes are still taken.
module phased_periodic_task_scheduler
    import pts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    pts_in_if.sink             i_req,
    pts_out_if.source          o_fire,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg cfg;

    pts_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pts_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (i_req),
        .o_fire  (o_fire)
    );

endmodule
